// File: src/tre_pkg.sv
package tre_pkg;

  // Field widths of the item and result
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned RATE_BITS     = 31;
  localparam int unsigned INTERVAL_BITS = 16;

  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd500;

  // 1000 * count needs ten more bits
  localparam int unsigned DVD_BITS = COUNT_BITS + 10;
  // quotient view at least one bit wider than a rate, for the saturation check
  localparam int unsigned QUOT_BITS = (DVD_BITS > RATE_BITS) ? DVD_BITS : RATE_BITS + 1;
  localparam int unsigned STEP_BITS = $clog2(DVD_BITS);

  localparam logic [RATE_BITS-1:0] RATE_MAX = {RATE_BITS{1'b1}};

  typedef enum logic [0:0] {
    REQ_REPORT  = 1'b0,
    REQ_RESTART = 1'b1
  } req_type_e;

  typedef struct packed {
    logic                  req_type;
    logic [COUNT_BITS-1:0] byte_count;
    logic [TIME_BITS-1:0]  time_ms;
  } tre_in_t;

  typedef struct packed {
    logic                 rate_new;
    logic [RATE_BITS-1:0] rate;
    logic [RATE_BITS-1:0] average_rate;
  } tre_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RATE,
    S_RATE_WAIT,
    S_AVG,
    S_AVG_WAIT,
    S_OUT
  } tre_state_e;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_MUL_A,
    DIV_MUL_B,
    DIV_STEP,
    DIV_DONE
  } tre_div_state_e;

endpackage

// File: src/tre_div.sv
module tre_div import tre_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COUNT_BITS-1:0] num_i,
  input  logic [TIME_BITS-1:0]  den_i,
  output logic                  done_o,
  output logic [RATE_BITS-1:0]  quot_o
);

  tre_div_state_e state_q, state_d;

  logic [COUNT_BITS-1:0] num_q, num_d;
  logic [TIME_BITS-1:0]  den_q, den_d;
  logic [DVD_BITS-1:0]   dvd_q, dvd_d;
  logic [TIME_BITS-1:0]  rem_q, rem_d;
  logic [STEP_BITS-1:0]  step_q, step_d;

  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS:0]    trial_diff;
  logic                  qbit;
  logic [QUOT_BITS-1:0]  quot_ext;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial      = {rem_q, dvd_q[DVD_BITS-1]};
  assign trial_diff = trial - {1'b0, den_q};
  assign qbit       = (trial >= {1'b0, den_q});
  assign quot_ext   = QUOT_BITS'(dvd_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE:  if (start_i) state_d = DIV_MUL_A;
      DIV_MUL_A: state_d = DIV_MUL_B;
      DIV_MUL_B: state_d = DIV_STEP;
      DIV_STEP:  if (step_q == STEP_BITS'(DVD_BITS - 1)) state_d = DIV_DONE;
      DIV_DONE:  state_d = DIV_IDLE;
      default:   state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    step_d = step_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          num_d  = num_i;
          den_d  = den_i;
          rem_d  = '0;
          step_d = '0;
        end
      end
      // 1000 * n = (n << 10) - (n << 4) - (n << 3)
      DIV_MUL_A: dvd_d = (DVD_BITS'(num_q) << 10) - (DVD_BITS'(num_q) << 4);
      DIV_MUL_B: dvd_d = dvd_q - (DVD_BITS'(num_q) << 3);
      DIV_STEP: begin
        rem_d  = qbit ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        dvd_d  = {dvd_q[DVD_BITS-2:0], qbit};
        step_d = step_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    done_o = (state_q == DIV_DONE);
    quot_o = (|quot_ext[QUOT_BITS-1:RATE_BITS]) ? RATE_MAX : quot_ext[RATE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

endmodule

// File: src/throughput_rate_estimator.sv
// Throughput rate estimator. Each item is either a restart request or a report of
// a cumulative count with a free-running millisecond timestamp; each item gives
// exactly one result. The first report after reset or restart sets the baseline.
// A later report is taken only if its count exceeds the last taken count and more
// than min_interval_ms has passed (time differences wrap modulo 2^32); then the
// interval rate floor(1000*dcount/dms), saturated at 2^31-1, is computed and
// rate_new flags a change. Every result also carries the average rate from the
// baseline to the last taken report (0 when no time has passed). One item at a
// time: a new item is accepted only after the previous one has reached the output
// register. An interval rate, when one is computed, and the average each take one
// run of the single shared divider; the average needs no run when no time has
// passed since the baseline. A run is a constant multiply by 1000, one restoring
// step per quotient bit (42 bits) and a done state. A finished result sits in the
// output register, so the next item can be taken while it waits; a held output
// stalls the block only once the next result is ready. min_interval_ms resets to
// 500 and is written through cfg_we_i.
module throughput_rate_estimator import tre_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [INTERVAL_BITS-1:0] cfg_data_i,
  // item in
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  tre_in_t                  in_data_i,
  // result out
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output tre_out_t                 out_data_o
);

  tre_state_e state_q, state_d;

  // item register
  logic                  req_q, req_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [TIME_BITS-1:0]  tm_q, tm_d;

  // measurement state
  logic                     running_q, running_d;
  logic [COUNT_BITS-1:0]    base_count_q, base_count_d;
  logic [TIME_BITS-1:0]     base_time_q, base_time_d;
  logic [COUNT_BITS-1:0]    prev_count_q, prev_count_d;
  logic [TIME_BITS-1:0]     prev_time_q, prev_time_d;
  logic [RATE_BITS-1:0]     prev_rate_q, prev_rate_d;
  logic [INTERVAL_BITS-1:0] min_ivl_q, min_ivl_d;

  // per-item result
  logic                 fresh_q, fresh_d;
  logic [RATE_BITS-1:0] avg_q, avg_d;

  // output register
  logic     out_valid_q, out_valid_d;
  tre_out_t out_q, out_d;

  // divider hookup
  logic                  div_start;
  logic [COUNT_BITS-1:0] div_num;
  logic [TIME_BITS-1:0]  div_den;
  logic                  div_done;
  logic [RATE_BITS-1:0]  div_quot;

  logic                  accept_in;
  logic                  load_out;

  // report decision, from the registered item
  logic [COUNT_BITS-1:0] dc_rate;
  logic [TIME_BITS-1:0]  dt_rate;
  logic                  take_report;
  // average terms, from the state after this item
  logic [COUNT_BITS-1:0] dc_avg;
  logic [TIME_BITS-1:0]  dt_avg;

  assign dc_rate     = cnt_q - prev_count_q;
  assign dt_rate     = tm_q - prev_time_q;
  assign take_report = (cnt_q > prev_count_q) && (dt_rate > TIME_BITS'(min_ivl_q));
  assign dc_avg      = prev_count_q - base_count_q;
  assign dt_avg      = prev_time_q - base_time_q;

  tre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE: begin
        if (req_q == REQ_RESTART || !running_q || !take_report) begin
          state_d = S_AVG;
        end else begin
          state_d = S_RATE;
        end
      end
      S_RATE:      state_d = S_RATE_WAIT;
      S_RATE_WAIT: if (div_done) state_d = S_AVG;
      S_AVG:       state_d = (dt_avg == '0) ? S_OUT : S_AVG_WAIT;
      S_AVG_WAIT:  if (div_done) state_d = S_OUT;
      S_OUT:       if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    accept_in  = (state_q == S_IDLE) && in_valid_i;
    div_start  = (state_q == S_RATE) || ((state_q == S_AVG) && (dt_avg != '0));
    div_num    = (state_q == S_RATE) ? dc_rate : dc_avg;
    div_den    = (state_q == S_RATE) ? dt_rate : dt_avg;
    load_out   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  end

  // datapath
  always_comb begin
    req_d        = req_q;
    cnt_d        = cnt_q;
    tm_d         = tm_q;
    running_d    = running_q;
    base_count_d = base_count_q;
    base_time_d  = base_time_q;
    prev_count_d = prev_count_q;
    prev_time_d  = prev_time_q;
    prev_rate_d  = prev_rate_q;
    fresh_d      = fresh_q;
    avg_d        = avg_q;
    min_ivl_d    = cfg_we_i ? cfg_data_i : min_ivl_q;

    if (accept_in) begin
      req_d = in_data_i.req_type;
      cnt_d = in_data_i.byte_count;
      tm_d  = in_data_i.time_ms;
    end

    case (state_q)
      S_DECIDE: begin
        fresh_d = 1'b0;
        if (req_q == REQ_RESTART) begin
          running_d = 1'b0;
        end else if (!running_q) begin
          // baseline report
          running_d    = 1'b1;
          base_count_d = cnt_q;
          base_time_d  = tm_q;
          prev_count_d = cnt_q;
          prev_time_d  = tm_q;
          prev_rate_d  = '0;
        end
      end
      S_RATE_WAIT: begin
        if (div_done) begin
          prev_count_d = cnt_q;
          prev_time_d  = tm_q;
          if (div_quot != prev_rate_q) begin
            prev_rate_d = div_quot;
            fresh_d     = 1'b1;
          end
        end
      end
      S_AVG: begin
        if (dt_avg == '0) avg_d = '0;
      end
      S_AVG_WAIT: begin
        if (div_done) avg_d = div_quot;
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d        = 1'b1;
      out_d.rate_new     = fresh_q;
      out_d.rate         = prev_rate_q;
      out_d.average_rate = avg_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      running_q    <= 1'b0;
      base_count_q <= '0;
      base_time_q  <= '0;
      prev_count_q <= '0;
      prev_time_q  <= '0;
      prev_rate_q  <= '0;
      min_ivl_q    <= INTERVAL_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      base_count_q <= base_count_d;
      base_time_q  <= base_time_d;
      prev_count_q <= prev_count_d;
      prev_time_q  <= prev_time_d;
      prev_rate_q  <= prev_rate_d;
      min_ivl_q    <= min_ivl_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    cnt_q   <= cnt_d;
    tm_q    <= tm_d;
    fresh_q <= fresh_d;
    avg_q   <= avg_d;
    out_q   <= out_d;
  end

endmodule

// File: bench/throughput_rate_estimator_test.sv
`timescale 1ns / 1ps

module throughput_rate_estimator_test;
  import tre_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_WAIT  = 150;
  localparam int unsigned LONG_HOLD    = 3000;
  localparam int unsigned PHASE_ITEMS  = 180;
  localparam int unsigned REPORT_LIMIT = 10;

  // Predicts one result per item and holds the results still owed by the block.
  class rate_scoreboard;
    logic [INTERVAL_BITS-1:0] min_gap;
    bit                       active;
    logic [COUNT_BITS-1:0]    base_cnt;
    logic [COUNT_BITS-1:0]    last_cnt;
    logic [TIME_BITS-1:0]     base_ms;
    logic [TIME_BITS-1:0]     last_ms;
    logic [RATE_BITS-1:0]     last_rate;
    tre_out_t                 owed_q[$];
    int unsigned              mismatches;

    function new();
      min_gap    = INTERVAL_RESET;
      active     = 1'b0;
      base_cnt   = '0;
      last_cnt   = '0;
      base_ms    = '0;
      last_ms    = '0;
      last_rate  = '0;
      mismatches = 0;
    endfunction

    function void set_interval(logic [INTERVAL_BITS-1:0] value);
      min_gap = value;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // floor(1000 * amount / span), clipped to the rate range; span is never 0 here
    static function logic [RATE_BITS-1:0] per_second(logic [COUNT_BITS-1:0] amount,
                                                     logic [TIME_BITS-1:0] span);
      logic [63:0] q;
      q = (64'(amount) * 64'd1000) / 64'(span);
      if (q > 64'(RATE_MAX)) return RATE_MAX;
      return q[RATE_BITS-1:0];
    endfunction

    function void note_item(tre_in_t it);
      tre_out_t                want;
      logic [TIME_BITS-1:0]    dt;
      logic [TIME_BITS-1:0]    span;
      logic [RATE_BITS-1:0]    r;
      want.rate_new = 1'b0;
      if (it.req_type == REQ_RESTART) begin
        active = 1'b0;
      end else if (!active) begin
        // baseline report
        active    = 1'b1;
        base_cnt  = it.byte_count;
        last_cnt  = it.byte_count;
        base_ms   = it.time_ms;
        last_ms   = it.time_ms;
        last_rate = '0;
      end else if (it.byte_count > last_cnt) begin
        dt = it.time_ms - last_ms;  // wraps
        if (dt > min_gap) begin
          r        = per_second(it.byte_count - last_cnt, dt);
          last_cnt = it.byte_count;
          last_ms  = it.time_ms;
          if (r != last_rate) begin
            last_rate     = r;
            want.rate_new = 1'b1;
          end
        end
      end
      want.rate = last_rate;
      span = last_ms - base_ms;
      want.average_rate = (span == 0) ? '0 : per_second(last_cnt - base_cnt, span);
      owed_q.push_back(want);
    endfunction

    function void check_result(tre_out_t got);
      tre_out_t want;
      if (owed_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: new=%0d rate=%0d avg=%0d",
                   got.rate_new, got.rate, got.average_rate);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (got.rate_new !== want.rate_new || got.rate !== want.rate ||
          got.average_rate !== want.average_rate) begin
        if (mismatches < REPORT_LIMIT)
          $display("mismatch: expected new=%0d rate=%0d avg=%0d, got new=%0d rate=%0d avg=%0d",
                   want.rate_new, want.rate, want.average_rate,
                   got.rate_new, got.rate, got.average_rate);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_we_i   = 1'b0;
  logic [INTERVAL_BITS-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  tre_in_t                  in_data_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  tre_out_t                 out_data_o;

  rate_scoreboard sb = new();

  // idling percentages for the current phase
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  // long receiver hold-off: main bumps hold_asked, receiver does the counting
  int unsigned hold_asked = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned cycle_count = 0;

  // random report stream: last offered count/time and last deltas
  logic [COUNT_BITS-1:0] gen_count = '0;
  logic [TIME_BITS-1:0]  gen_time  = '0;
  logic [COUNT_BITS-1:0] gen_dc    = 32'd1;
  logic [TIME_BITS-1:0]  gen_dt    = 32'd600;
  bit                    gen_jump  = 1'b1;

  throughput_rate_estimator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: outputs sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // stall driven at the falling edge; a requested long hold wins over random stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high on exit so back-to-back
  // items need no drop.
  task automatic send_item(input tre_in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic send_report(input logic [31:0] cnt, input logic [31:0] ms);
    tre_in_t it;
    it.req_type   = REQ_REPORT;
    it.byte_count = cnt;
    it.time_ms    = ms;
    send_item(it);
  endtask

  task automatic send_restart(input logic [31:0] cnt, input logic [31:0] ms);
    tre_in_t it;
    it.req_type   = REQ_RESTART;
    it.byte_count = cnt;
    it.time_ms    = ms;
    send_item(it);
  endtask

  // stop offering, wait for every owed result, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
  endtask

  task automatic write_interval(input logic [INTERVAL_BITS-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_interval(value);
    @(negedge clk_i);
  endtask

  // Mostly well-formed report streams with random deltas; some restarts,
  // fresh baselines and unrelated noise mixed in.
  task automatic make_item(output tre_in_t it);
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    span = 2 * sb.min_gap + 100;
    it.req_type   = REQ_REPORT;
    it.byte_count = $urandom;
    it.time_ms    = $urandom;
    if (pick < 3) begin
      it.req_type = REQ_RESTART;
      gen_jump    = 1'b1;
    end else if (pick < 8) begin
      // noise: random count and time, stream untouched
    end else if (gen_jump || pick < 11) begin
      gen_count = it.byte_count;
      gen_time  = it.time_ms;
      gen_jump  = 1'b0;
    end else begin
      // below 21 the last deltas repeat, which tends to give an unchanged rate
      if (pick >= 21) begin
        case ($urandom_range(9))
          0:       gen_dc = '0;
          1, 2, 3: gen_dc = $urandom_range(255);
          4, 5, 6: gen_dc = $urandom_range(1 << 20);
          default: gen_dc = $urandom;
        endcase
        gen_dt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(span);
      end
      gen_count     = gen_count + gen_dc;
      gen_time      = gen_time + gen_dt;
      it.byte_count = gen_count;
      it.time_ms    = gen_time;
    end
  endtask

  initial begin
    tre_in_t                  it;
    logic [INTERVAL_BITS-1:0] gap;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, interval at its reset value of 500
    send_restart(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // restart from reset state
    send_report(32'd0, 32'hFFFF_FF00);           // baseline, average 0
    send_report(32'd0, 32'h0000_0100);           // count not larger
    send_report(32'd1000, 32'h0000_00F4);        // exactly 500 ms across the wrap: too short
    send_report(32'd1000, 32'h0000_00F5);        // 501 ms, accepted
    send_report(32'd2000, 32'h0000_02EA);        // same delta: unchanged rate
    send_report(32'd1500, 32'h0000_1000);        // smaller count
    send_report(32'hFFFF_FFFF, 32'h0000_0542);   // saturates
    send_restart(32'd0, 32'd0);
    send_report(32'hFFFF_FFFF, 32'd0);           // baseline at count max
    send_report(32'hFFFF_FFFF, 32'h0001_0000);   // equal count ignored
    send_restart(32'd0, 32'd0);
    send_report(32'd0, 32'd0);
    send_report(32'd1, 32'hFFFF_FFFF);           // longest span, rate rounds to 0
    send_report(32'd5000, 32'h0000_03E7);        // wraps, rate 4999
    drain_results();

    write_interval('0);
    send_report(32'd6000, 32'h0000_03E8);        // 1 ms beats a zero interval
    send_report(32'd6001, 32'h0000_03E8);        // no time passed
    send_report(32'h8000_0000, 32'h0000_03E9);   // saturates
    drain_results();

    write_interval({INTERVAL_BITS{1'b1}});
    send_report(32'h8000_0001, 32'h0001_03E8);   // exactly 65535 ms: too short
    send_report(32'h8000_0002, 32'h0001_03E9);   // 65536 ms, accepted
    drain_results();

    // random phases, cycling through the idling modes
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       gap = INTERVAL_RESET;
        1:       gap = '0;
        2:       gap = {INTERVAL_BITS{1'b1}};
        4:       gap = 16'd1;
        default: gap = INTERVAL_BITS'(($urandom_range(3) == 0) ?
                                      $urandom : $urandom_range(2000));
      endcase
      write_interval(gap);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // long hold-off while the sender keeps offering, so the input backs up
      if (p == 4) hold_asked++;
      repeat (PHASE_ITEMS) begin
        make_item(it);
        send_item(it);
      end
      drain_results();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
